// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is applied
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tvpsg_pkg.sv =====
// types, codes and the envelope shape function of the sound generator
package tvpsg_pkg;

	// bus operation codes
	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_SELECT = 2'd1;
	localparam logic [1:0] FUNC_WRITE  = 2'd2;
	localparam logic [1:0] FUNC_READ   = 2'd3;

	// register file map
	localparam int unsigned NUM_REGS = 16;
	localparam int unsigned NUM_CH   = 3;
	localparam logic [3:0] REG_TONE_A_LO = 4'd0;
	localparam logic [3:0] REG_NOISE     = 4'd6;
	localparam logic [3:0] REG_MIXER     = 4'd7;
	localparam logic [3:0] REG_VOL_A     = 4'd8;
	localparam logic [3:0] REG_ENV_LO    = 4'd11;
	localparam logic [3:0] REG_ENV_HI    = 4'd12;
	localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

	// envelope position where the loop restarts after the last position
	localparam logic [6:0] ENV_POS_LAST = 7'd127;
	localparam logic [6:0] ENV_POS_LOOP = 7'd64;

	// register contents seen by the generators
	typedef struct packed {
		logic [NUM_CH-1:0][11:0] tone_per;
		logic [4:0]              noise_per;
		logic [15:0]             env_per;
		logic [5:0]              mixer;
		logic [NUM_CH-1:0][4:0]  vol;
	} gen_regs_t;

	// per-item control toward the generators
	typedef struct packed {
		logic       tick;
		logic       env_restart;
		logic [3:0] env_shape;
	} gen_ctrl_t;

	// per-tick channel outputs
	typedef struct packed {
		logic [NUM_CH-1:0]      active;
		logic [NUM_CH-1:0][4:0] level;
	} gen_out_t;

	// envelope level for a shape at a position
	// shape bits: 3 continue, 2 attack, 1 alternate, 0 hold
	function automatic logic [4:0] env_level(input logic [3:0] shape, input logic [6:0] pos);
		logic up;
		logic [4:0] ramp;
		logic [4:0] res;
		ramp = pos[4:0];
		if (pos[6:5] == 2'b00) begin
			// first ramp
			up = shape[2];
			res = up ? ramp : ~ramp;
		end else if (!shape[3]) begin
			// one shot, then silent
			up = 1'b0;
			res = 5'd0;
		end else if (shape[0]) begin
			// held at one end: where the first ramp ended, or at the opposite end when alternating
			up = shape[2] ^ shape[1];
			res = up ? 5'h1F : 5'd0;
		end else begin
			// repeating ramps, direction flips every segment when alternating
			up = shape[2] ^ (shape[1] & pos[5]);
			res = up ? ramp : ~ramp;
		end
		return res;
	endfunction

endpackage

// ===== rtl/tvpsg_gen.sv =====
// tone, noise and envelope generators with the channel mixer
`include "assert_macros.svh"

module tvpsg_gen (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tvpsg_pkg::gen_ctrl_t  ctrl,
	input  tvpsg_pkg::gen_regs_t  regs,
	output tvpsg_pkg::gen_out_t   gen_out
);

	localparam int unsigned NCH = tvpsg_pkg::NUM_CH;

	logic [NCH-1:0][11:0] tone_cnt_q;
	logic [NCH-1:0][11:0] tone_cnt_d;
	logic [NCH-1:0]       tone_bit_q;
	logic [NCH-1:0]       tone_bit_d;
	logic [5:0]           noise_cnt_q;
	logic [5:0]           noise_cnt_d;
	logic [16:0]          noise_shift_q;
	logic [16:0]          noise_shift_d;
	logic                 noise_bit_q;
	logic                 noise_bit_d;
	logic [15:0]          env_cnt_q;
	logic [15:0]          env_cnt_d;
	logic [6:0]           env_pos_q;
	logic [6:0]           env_pos_d;
	logic [3:0]           env_shape_q;
	logic [4:0]           env_lvl;

	// tone dividers
	always_comb begin
		logic [12:0] inc;
		for (int ch = 0; ch < NCH; ch++) begin
			inc = {1'b0, tone_cnt_q[ch]} + 13'd1;
			if (inc >= {1'b0, regs.tone_per[ch]}) begin
				tone_cnt_d[ch] = 12'd0;
				tone_bit_d[ch] = ~tone_bit_q[ch];
			end else begin
				tone_cnt_d[ch] = inc[11:0];
				tone_bit_d[ch] = tone_bit_q[ch];
			end
		end
	end

	// noise divider and lfsr
	always_comb begin
		logic [6:0] inc;
		logic       fb;
		inc = {1'b0, noise_cnt_q} + 7'd1;
		fb = noise_shift_q[16] ^ noise_shift_q[13];
		if (inc >= {1'b0, regs.noise_per, 1'b0}) begin
			noise_cnt_d = 6'd0;
			noise_shift_d = {noise_shift_q[15:0], ~fb};
			noise_bit_d = noise_shift_q[15];
		end else begin
			noise_cnt_d = inc[5:0];
			noise_shift_d = noise_shift_q;
			noise_bit_d = noise_bit_q;
		end
	end

	// envelope divider and position
	always_comb begin
		logic [16:0] inc;
		inc = {1'b0, env_cnt_q} + 17'd1;
		if (inc >= {1'b0, regs.env_per}) begin
			env_cnt_d = 16'd0;
			env_pos_d = (env_pos_q == tvpsg_pkg::ENV_POS_LAST) ? tvpsg_pkg::ENV_POS_LOOP
				: env_pos_q + 7'd1;
		end else begin
			env_cnt_d = inc[15:0];
			env_pos_d = env_pos_q;
		end
	end

	assign env_lvl = tvpsg_pkg::env_level(env_shape_q, env_pos_d);

	// mixer on the updated generator bits
	always_comb begin
		logic tone_on;
		logic noise_on;
		for (int ch = 0; ch < NCH; ch++) begin
			tone_on = tone_bit_d[ch] & ~regs.mixer[ch];
			noise_on = noise_bit_d & ~regs.mixer[NCH + ch];
			gen_out.active[ch] = tone_on | noise_on;
			if (!(tone_on | noise_on))
				gen_out.level[ch] = 5'd0;
			else if (regs.vol[ch][4])
				gen_out.level[ch] = env_lvl;
			else
				gen_out.level[ch] = {regs.vol[ch][3:0], 1'b1};
		end
	end

	// generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_cnt_q <= '0;
			tone_bit_q <= '0;
			noise_cnt_q <= '0;
			noise_shift_q <= '0;
			noise_bit_q <= 1'b0;
			env_cnt_q <= '0;
			env_pos_q <= '0;
			env_shape_q <= '0;
		end else if (ctrl.tick) begin
			tone_cnt_q <= tone_cnt_d;
			tone_bit_q <= tone_bit_d;
			noise_cnt_q <= noise_cnt_d;
			noise_shift_q <= noise_shift_d;
			noise_bit_q <= noise_bit_d;
			env_cnt_q <= env_cnt_d;
			env_pos_q <= env_pos_d;
		end else if (ctrl.env_restart) begin
			env_cnt_q <= '0;
			env_pos_q <= '0;
			env_shape_q <= ctrl.env_shape;
		end
	end

	// checks
	`ASSERT_CLK(a_env_restart_clears, ctrl.env_restart && !ctrl.tick |=> env_pos_q == 7'd0 && env_cnt_q == 16'd0, "envelope restart did not clear position and counter")
	`ASSERT_CLK_ALWAYS(a_noise_bit_msb, noise_bit_q == noise_shift_q[16], "noise bit out of step with lfsr")
	`ASSERT_CLK(a_env_idle_stable, !ctrl.tick && !ctrl.env_restart |=> $stable(env_cnt_q) && $stable(env_pos_q), "envelope moved without a tick")

endmodule

// ===== rtl/three_voice_tone_noise_envelope_psg_core.sv =====
// top level of the three-voice sound generator: bus decode, register file, result register
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------------
//  in      | in_valid / in_ready | func, value
//  out     | out_valid/out_ready | read_data, active_a/b/c, level_a/b/c
//
// one item per cycle sustained unless out stalls; an item enters the input register when it
// is accepted, and its result goes on to the out ports through the result register.
// the input register holds the item while the result register is full and not taken, so
// in_ready drops only on a stall of out.
// reset clears the register file, the select index and all generator state.
`include "assert_macros.svh"

module three_voice_tone_noise_envelope_psg_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       active_a,
	output logic       active_b,
	output logic       active_c,
	output logic [4:0] level_a,
	output logic [4:0] level_b,
	output logic [4:0] level_c
);

	localparam int unsigned NREG = tvpsg_pkg::NUM_REGS;
	localparam int unsigned NCH  = tvpsg_pkg::NUM_CH;

	logic                 valid_s1;
	logic [1:0]           func_s1;
	logic [7:0]           value_s1;
	logic                 advance;
	logic [NREG-1:0][7:0] regs_q;
	logic [3:0]           sel_q;
	tvpsg_pkg::gen_regs_t gen_regs;
	tvpsg_pkg::gen_ctrl_t gen_ctrl;
	tvpsg_pkg::gen_out_t  gen_out;
	logic                 out_valid_q;
	logic [7:0]           read_data_q;
	logic [NCH-1:0]       active_q;
	logic [NCH-1:0][4:0]  level_q;

	// pipeline control
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func;
			value_s1 <= value;
		end
	end

	// register file and select index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
			sel_q <= '0;
		end else if (advance) begin
			if (func_s1 == tvpsg_pkg::FUNC_SELECT)
				sel_q <= value_s1[3:0];
			if (func_s1 == tvpsg_pkg::FUNC_WRITE)
				regs_q[sel_q] <= value_s1;
		end
	end

	// register fields for the generators
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			gen_regs.tone_per[ch] = {regs_q[tvpsg_pkg::REG_TONE_A_LO + 4'(2 * ch + 1)][3:0],
				regs_q[tvpsg_pkg::REG_TONE_A_LO + 4'(2 * ch)]};
			gen_regs.vol[ch] = regs_q[tvpsg_pkg::REG_VOL_A + 4'(ch)][4:0];
		end
		gen_regs.noise_per = regs_q[tvpsg_pkg::REG_NOISE][4:0];
		gen_regs.env_per = {regs_q[tvpsg_pkg::REG_ENV_HI], regs_q[tvpsg_pkg::REG_ENV_LO]};
		gen_regs.mixer = regs_q[tvpsg_pkg::REG_MIXER][5:0];
	end

	// generator control for the item in the input register
	assign gen_ctrl.tick = advance && (func_s1 == tvpsg_pkg::FUNC_TICK);
	assign gen_ctrl.env_restart = advance && (func_s1 == tvpsg_pkg::FUNC_WRITE)
		&& (sel_q == tvpsg_pkg::REG_ENV_SHAPE);
	assign gen_ctrl.env_shape = value_s1[3:0];

	tvpsg_gen u_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (gen_ctrl),
		.regs    (gen_regs),
		.gen_out (gen_out)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= (func_s1 == tvpsg_pkg::FUNC_READ) ? regs_q[sel_q] : 8'd0;
			if (func_s1 == tvpsg_pkg::FUNC_TICK) begin
				active_q <= gen_out.active;
				level_q <= gen_out.level;
			end else begin
				active_q <= '0;
				level_q <= '0;
			end
		end
	end

	// outputs
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign active_a = active_q[0];
	assign active_b = active_q[1];
	assign active_c = active_q[2];
	assign level_a = level_q[0];
	assign level_b = level_q[1];
	assign level_c = level_q[2];

	// checks
	`ASSERT_CLK(a_no_tick_silent, advance && func_s1 != tvpsg_pkg::FUNC_TICK |=> active_q == '0 && level_q == '0, "non-tick item produced channel output")
	`ASSERT_CLK(a_no_read_zero, advance && func_s1 != tvpsg_pkg::FUNC_READ |=> read_data_q == 8'd0, "read data on a non-read item")
	`ASSERT_CLK(a_stall_holds_item, valid_s1 && !advance |=> valid_s1 && $stable(func_s1) && $stable(value_s1), "input register lost an item during a stall")
	`ASSERT_CLK(a_inactive_level_zero, out_valid_q && !active_q[0] |-> level_q[0] == 5'd0, "inactive channel with a nonzero level")

endmodule
